FILE: src/address_table_with_aging_defines.svh
// assertion macros for the address table
`ifndef ADDRESS_TABLE_WITH_AGING_DEFINES_SVH
`define ADDRESS_TABLE_WITH_AGING_DEFINES_SVH
// plain implication check
`define ATA_ASSERT_IMP(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
    else $error("assertion failed");
// next-cycle implication check
`define ATA_ASSERT_NXT(lbl, clk, rst_n, a, c) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
    else $error("assertion failed");
`endif

FILE: src/ata_pkg.sv
// ---------------------------------------------------------------------------
// ata_pkg
// shared types and constants of the address table
// ---------------------------------------------------------------------------
package ata_pkg;
  localparam int TableDepthDef = 64;
  localparam logic [23:0] DefLifeRst = 24'd10000;
  localparam logic [15:0] AgeStepRst = 16'd5;

  localparam logic [2:0] CMD_LOOKUP = 3'd0;
  localparam logic [2:0] CMD_INSERT = 3'd1;
  localparam logic [2:0] CMD_DELETE = 3'd2;
  localparam logic [2:0] CMD_DELALL = 3'd3;
  localparam logic [2:0] CMD_SETLIFE = 3'd4;
  localparam logic [2:0] CMD_AGE = 3'd5;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [1:0] ST_EMPTY = 2'd2;
  localparam logic [1:0] ST_FULL = 2'd3;

  localparam logic CFG_DEF_LIFE = 1'b0;
  localparam logic CFG_AGE_STEP = 1'b1;

  typedef struct packed {
    logic [2:0]  command;
    logic [31:0] ip_addr;
    logic [47:0] hw_addr;
    logic        is_dynamic;
    logic [23:0] new_lifetime;
  } cmd_t;

  localparam int CmdW = $bits(cmd_t);
endpackage

FILE: src/ata_ram.sv
// ---------------------------------------------------------------------------
// ata_ram
// generic RAM with one write port and one registered read port
// ---------------------------------------------------------------------------
module ata_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

FILE: src/ata_front.sv
// ---------------------------------------------------------------------------
// ata_front
// accepts command words into a two-entry queue toward the back end
// ---------------------------------------------------------------------------
module ata_front (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  ata_pkg::cmd_t in_word,
  output logic          q_valid,
  output ata_pkg::cmd_t q_word,
  input  logic          q_take
);
  import ata_pkg::*;

  cmd_t q_r [2];
  logic [1:0] cnt_r, cnt_nxt;
  logic rd_r, rd_nxt;
  logic wr_r, wr_nxt;
  logic push, pop;

  assign in_stall = (cnt_r == 2'd2);
  assign push = in_valid && !in_stall;
  assign q_valid = (cnt_r != 2'd0);
  assign pop = q_take && q_valid;
  assign q_word = q_r[rd_r];

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
    rd_nxt = rd_r ^ pop;
    wr_nxt = wr_r ^ push;
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= in_word;
    if (!rst_n) begin
      cnt_r <= '0;
      rd_r <= 1'b0;
      wr_r <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      rd_r <= rd_nxt;
      wr_r <= wr_nxt;
    end
  end
endmodule

FILE: src/ata_back.sv
// ---------------------------------------------------------------------------
// ata_back
// walks the table one slot per cycle for lookup, insert, delete, setlife and age
// ---------------------------------------------------------------------------
module ata_back #(
  parameter int DEPTH = ata_pkg::TableDepthDef
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          q_valid,
  input  ata_pkg::cmd_t q_word,
  output logic          q_take,
  input  logic [23:0]   def_life,
  input  logic [15:0]   age_step,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [1:0]    out_status,
  output logic [47:0]   out_found_mac,
  output logic          out_found_dynamic,
  output logic [23:0]   out_found_lifetime
);
  import ata_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(DEPTH - 1);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;
  localparam logic [1:0] S_OUT = 2'd3;

  logic [1:0] st_r, st_nxt;
  cmd_t cmd_r;
  logic [AW-1:0] idx_r, idx_nxt;   // read address presented to ram
  logic [AW-1:0] chk_r;            // slot whose data is on ram output
  logic chk_v_r, chk_v_nxt;
  logic [DEPTH-1:0] valid_r, valid_nxt;
  logic [CW-1:0] fill_r, fill_nxt;
  logic hit_r, hit_nxt;
  logic [AW-1:0] hit_idx_r, hit_idx_nxt;
  logic free_any_r, free_any_nxt;
  logic [AW-1:0] free_idx_r, free_idx_nxt;
  logic [1:0] status_r, status_nxt;
  logic [47:0] fmac_r, fmac_nxt;
  logic fdyn_r, fdyn_nxt;
  logic [23:0] flife_r, flife_nxt;
  logic ov_r, ov_nxt;

  // ram ports
  logic we;
  logic [AW-1:0] raddr;
  logic [AW-1:0] waddr;
  logic [31:0] ip_q;
  logic [47:0] mac_q;
  logic dyn_q;
  logic [23:0] life_q, life_w;
  logic [31:0] ip_w;
  logic [47:0] mac_w;
  logic dyn_w;

  ata_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_ip (
    .clk(clk), .we(we), .waddr(waddr), .wdata(ip_w), .raddr(raddr), .rdata(ip_q));
  ata_ram #(.WIDTH(48), .DEPTH(DEPTH)) u_mac (
    .clk(clk), .we(we), .waddr(waddr), .wdata(mac_w), .raddr(raddr), .rdata(mac_q));
  ata_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_dyn (
    .clk(clk), .we(we), .waddr(waddr), .wdata(dyn_w), .raddr(raddr), .rdata(dyn_q));
  ata_ram #(.WIDTH(24), .DEPTH(DEPTH)) u_life (
    .clk(clk), .we(we), .waddr(waddr), .wdata(life_w), .raddr(raddr), .rdata(life_q));

  logic match;
  logic scan_cmd;
  logic start;

  assign match = chk_v_r && valid_r[chk_r] && (ip_q == cmd_r.ip_addr);
  assign scan_cmd = (cmd_r.command == CMD_LOOKUP) || (cmd_r.command == CMD_INSERT) ||
                    (cmd_r.command == CMD_DELETE) || (cmd_r.command == CMD_SETLIFE) ||
                    (cmd_r.command == CMD_AGE);
  // a waiting result word holds the next command off
  assign q_take = (st_r == S_IDLE) && !(ov_r && out_stall);
  assign start = q_take && q_valid;
  assign out_valid = ov_r;
  assign out_status = status_r;
  assign out_found_mac = fmac_r;
  assign out_found_dynamic = fdyn_r;
  assign out_found_lifetime = flife_r;

  always_comb begin
    st_nxt = st_r;
    idx_nxt = idx_r;
    chk_v_nxt = 1'b0;
    valid_nxt = valid_r;
    fill_nxt = fill_r;
    hit_nxt = hit_r;
    hit_idx_nxt = hit_idx_r;
    free_any_nxt = free_any_r;
    free_idx_nxt = free_idx_r;
    status_nxt = status_r;
    fmac_nxt = fmac_r;
    fdyn_nxt = fdyn_r;
    flife_nxt = flife_r;
    ov_nxt = ov_r && out_stall;
    we = 1'b0;
    raddr = idx_r;
    waddr = chk_r;
    ip_w = cmd_r.ip_addr;
    mac_w = cmd_r.hw_addr;
    dyn_w = cmd_r.is_dynamic;
    life_w = def_life;
    unique case (st_r)
      S_IDLE: begin
        raddr = '0;
        if (start) begin
          st_nxt = S_SCAN;
          idx_nxt = (DEPTH > 1) ? AW'(1) : '0;
          chk_v_nxt = 1'b1;
          hit_nxt = 1'b0;
          free_any_nxt = 1'b0;
          status_nxt = ST_OK;
          fmac_nxt = '0;
          fdyn_nxt = 1'b0;
          flife_nxt = '0;
        end
      end
      S_SCAN: begin
        // data of slot chk_r is on the ram outputs; write back at chk_r, read idx_r
        if (!scan_cmd) begin
          if (cmd_r.command == CMD_DELALL) begin
            if (fill_r == '0) status_nxt = ST_EMPTY;
            valid_nxt = '0;
            fill_nxt = '0;
          end
          st_nxt = S_DONE;
        end else begin
          if (match) begin
            hit_nxt = 1'b1;
            hit_idx_nxt = chk_r;
          end
          // slots are walked upward, so the first free one is the lowest
          if (chk_v_r && !valid_r[chk_r] && !free_any_r) begin
            free_any_nxt = 1'b1;
            free_idx_nxt = chk_r;
          end
          if (chk_v_r && valid_r[chk_r] && dyn_q) begin
            if (cmd_r.command == CMD_SETLIFE) begin
              we = 1'b1;
              ip_w = ip_q;
              mac_w = mac_q;
              dyn_w = dyn_q;
              life_w = cmd_r.new_lifetime;
            end else if (cmd_r.command == CMD_AGE) begin
              if (life_q <= {8'd0, age_step}) begin
                valid_nxt[chk_r] = 1'b0;
                fill_nxt = fill_nxt - CW'(1);
              end else begin
                we = 1'b1;
                ip_w = ip_q;
                mac_w = mac_q;
                dyn_w = dyn_q;
                life_w = life_q - {8'd0, age_step};
              end
            end
          end
          if (match && cmd_r.command == CMD_LOOKUP) begin
            fmac_nxt = mac_q;
            fdyn_nxt = dyn_q;
            flife_nxt = dyn_q ? life_q : '0;
          end
          if (chk_r == LastIdx) begin
            st_nxt = S_DONE;
          end else begin
            chk_v_nxt = 1'b1;
            if (idx_r != LastIdx) idx_nxt = idx_r + AW'(1);
          end
        end
      end
      S_DONE: begin
        waddr = hit_idx_r;
        unique case (cmd_r.command)
          CMD_LOOKUP: begin
            if (fill_r == '0) status_nxt = ST_EMPTY;
            else if (!hit_r) status_nxt = ST_NOT_FOUND;
          end
          CMD_DELETE: begin
            if (fill_r == '0) status_nxt = ST_EMPTY;
            else if (!hit_r) status_nxt = ST_NOT_FOUND;
            else begin
              valid_nxt[hit_idx_r] = 1'b0;
              fill_nxt = fill_r - CW'(1);
            end
          end
          CMD_INSERT: begin
            if (hit_r) begin
              we = 1'b1;
            end else if (free_any_r) begin
              waddr = free_idx_r;
              we = 1'b1;
              valid_nxt[free_idx_r] = 1'b1;
              fill_nxt = fill_r + CW'(1);
            end else begin
              status_nxt = ST_FULL;
            end
          end
          default: ;
        endcase
        st_nxt = S_OUT;
      end
      S_OUT: begin
        if (!ov_r || !out_stall) begin
          ov_nxt = 1'b1;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  // pipeline address: the slot checked is the registered read address
  always_ff @(posedge clk) begin
    if (start) cmd_r <= q_word;
    chk_r <= raddr;
    hit_idx_r <= hit_idx_nxt;
    free_any_r <= free_any_nxt;
    free_idx_r <= free_idx_nxt;
    status_r <= status_nxt;
    fmac_r <= fmac_nxt;
    fdyn_r <= fdyn_nxt;
    flife_r <= flife_nxt;
    hit_r <= hit_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      valid_r <= '0;
      fill_r <= '0;
      ov_r <= 1'b0;
      chk_v_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      valid_r <= valid_nxt;
      fill_r <= fill_nxt;
      ov_r <= ov_nxt;
      chk_v_r <= chk_v_nxt;
      idx_r <= idx_nxt;
    end
  end
endmodule

FILE: src/address_table_with_aging.sv
// result word: the back end walks every table slot in S_SCAN, then sets status in S_DONE
// and raises the result in S_OUT; delete all and unknown commands skip the walk
// throughput: one command at a time in the back end, one table slot read per cycle
// a two-word queue in front takes new commands while the walk runs; a stalled
// result word holds the back end before it starts the next command
// reset: synchronous active-low; clears valid bits, fill count, queue and config registers to defaults
// ---------------------------------------------------------------------------
// address_table_with_aging
// ip to mac table with static and dynamic entries and lifetime aging
// ---------------------------------------------------------------------------
module address_table_with_aging #(
  parameter int TABLE_DEPTH = ata_pkg::TableDepthDef
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [23:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [31:0] in_ip_addr,
  input  logic [47:0] in_hw_addr,
  input  logic        in_is_dynamic,
  input  logic [23:0] in_new_lifetime,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_status,
  output logic [47:0] out_found_mac,
  output logic        out_found_dynamic,
  output logic [23:0] out_found_lifetime
);
  import ata_pkg::*;

  logic [23:0] def_life_r;
  logic [15:0] age_step_r;
  cmd_t in_word, q_word;
  logic q_valid, q_take;

  assign in_word = '{command: in_command, ip_addr: in_ip_addr, hw_addr: in_hw_addr,
                     is_dynamic: in_is_dynamic, new_lifetime: in_new_lifetime};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      def_life_r <= DefLifeRst;
      age_step_r <= AgeStepRst;
    end else if (cfg_we) begin
      if (cfg_index == CFG_DEF_LIFE) def_life_r <= cfg_data;
      else age_step_r <= cfg_data[15:0];
    end
  end

  ata_front u_front (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_word(in_word), .q_valid(q_valid), .q_word(q_word), .q_take(q_take));

  ata_back #(.DEPTH(TABLE_DEPTH)) u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_word(q_word), .q_take(q_take),
    .def_life(def_life_r), .age_step(age_step_r), .out_valid(out_valid),
    .out_stall(out_stall), .out_status(out_status), .out_found_mac(out_found_mac),
    .out_found_dynamic(out_found_dynamic), .out_found_lifetime(out_found_lifetime));
endmodule

FILE: src/ata_checker.sv
// ---------------------------------------------------------------------------
// ata_checker
// port-level checks of the address table
// ---------------------------------------------------------------------------
`include "address_table_with_aging_defines.svh"
module ata_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic [1:0]  out_status,
  input logic        out_found_dynamic,
  input logic [23:0] out_found_lifetime,
  input logic [47:0] out_found_mac
);
  import ata_pkg::*;
  `ATA_ASSERT_NXT(a_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_status))
  `ATA_ASSERT_IMP(a_life, clk, rst_n, out_valid && !out_found_dynamic, out_found_lifetime == '0)
  `ATA_ASSERT_IMP(a_mac, clk, rst_n, out_valid && out_status != ST_OK, out_found_mac == '0)
endmodule

bind address_table_with_aging ata_checker u_chk (
  .clk(clk), .rst_n(rst_n), .out_valid(out_valid), .out_stall(out_stall),
  .out_status(out_status), .out_found_dynamic(out_found_dynamic),
  .out_found_lifetime(out_found_lifetime), .out_found_mac(out_found_mac));
